FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and held off during rst
`define BC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and held off during rst
`define BC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/baro_pkg.sv
package baro_pkg;

  typedef enum logic [2:0] {
    CFG_COEF0 = 3'd0,
    CFG_COEF1 = 3'd1,
    CFG_COEF2 = 3'd2,
    CFG_OSR_P = 3'd3,
    CFG_OSR_T = 3'd4
  } cfg_reg_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int CodeW    = 24;
  localparam int ScaledW  = 27;
  localparam int MulAW    = 48;
  localparam int MulQW    = 55;
  localparam int SatInW   = 43;

  localparam logic [14:0] RECIP [8] = '{
    15'd8192, 15'd2731, 15'd1170, 15'd546,
    15'd16913, 15'd8322, 15'd4128, 15'd2056
  };

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SatInW-1:0] x);
    sat_t r;
    r.clip  = 1'b0;
    r.value = x[31:0];
    if (x > SatInW'(signed'(32'sh7fffffff))) begin
      r.clip  = 1'b1;
      r.value = 32'sh7fffffff;
    end else if (x < SatInW'(signed'(32'sh80000000))) begin
      r.clip  = 1'b1;
      r.value = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

FILE: src/bc_in_if.sv
interface bc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pressure_code;
  logic [23:0] temperature_code;

  modport source (output valid, pressure_code, temperature_code, input ready);
  modport sink (input valid, pressure_code, temperature_code, output ready);
endinterface

FILE: src/bc_out_if.sv
interface bc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pressure_signed;
  logic signed [23:0] temperature_signed;
  logic signed [31:0] temperature_fixed;
  logic signed [31:0] pressure_fixed;
  logic               clipped;

  modport source (output valid, pressure_signed, temperature_signed, temperature_fixed,
                  pressure_fixed, clipped, input ready);
  modport sink (input valid, pressure_signed, temperature_signed, temperature_fixed,
                pressure_fixed, clipped, output ready);
endinterface

FILE: src/bc_cfg_if.sv
interface bc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/bc_mulq20.sv
module bc_mulq20 (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [baro_pkg::MulAW-1:0]   a,
  input  logic signed [baro_pkg::ScaledW-1:0] s,
  output logic signed [baro_pkg::MulQW-1:0]   q
);

  logic signed [50:0] ph;
  logic signed [51:0] pl;
  logic signed [74:0] full;
  logic signed [23:0] ah;
  logic signed [24:0] al;

  assign ah = signed'(a[47:24]);
  assign al = signed'({1'b0, a[23:0]});

  // split partial products, then recombine with round half up
  always_ff @(posedge clk) begin
    if (en) begin
      ph <= ah * s;
      pl <= al * s;
    end
  end

  assign full = (75'(ph) <<< 24) + 75'(pl) + 75'sd524288;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= full[74:20];
    end
  end

endmodule

FILE: src/barometer_compensation.sv
// Barometric compensation pipeline: takes one raw pressure/temperature code pair per
// cycle and returns the raw values reinterpreted as signed, temperature in 1/256 degC and
// pressure in 1/64 Pa (both saturated to signed 32 bits, clipped flags saturation).
// There are eleven register stages; their depth is set by four 48x27 multiplies in
// two parallel pairs, each split into two partial products over two stages. Throughput
// is one pair per cycle; when the result is not taken the whole pipeline holds. The
// user must write calibration and oversampling registers only while idle; the block
// itself does not enforce it.
`include "assert_macros.svh"

module barometer_compensation (
  input  logic      clk,
  input  logic      rst,
  bc_in_if.sink     sample,
  bc_out_if.source  result,
  bc_cfg_if.sink    cfg
);

  logic [47:0] coef0, coef1, coef2;
  logic [2:0]  osr_p, osr_t;
  logic        en;
  logic        v [1:11];

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0  = signed'(coef0[47:36]);
  assign c1  = signed'(coef0[35:24]);
  assign c00 = signed'(coef0[23:4]);
  assign c10 = signed'({coef0[3:0], coef1[47:32]});
  assign c01 = signed'(coef1[31:16]);
  assign c11 = signed'(coef1[15:0]);
  assign c20 = signed'(coef2[47:32]);
  assign c21 = signed'(coef2[31:16]);
  assign c30 = signed'(coef2[15:0]);

  assign cfg.ready    = 1'b1;
  assign en           = !v[11] || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef0 <= '0;
      coef1 <= '0;
      coef2 <= '0;
      osr_p <= '0;
      osr_t <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        baro_pkg::CFG_COEF0: coef0 <= cfg.data;
        baro_pkg::CFG_COEF1: coef1 <= cfg.data;
        baro_pkg::CFG_COEF2: coef2 <= cfg.data;
        baro_pkg::CFG_OSR_P: osr_p <= cfg.data[2:0];
        baro_pkg::CFG_OSR_T: osr_t <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 11; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[1] <= sample.valid;
      for (int i = 2; i <= 11; i++) v[i] <= v[i-1];
    end
  end

  logic [23:0]        pc_q [1:10];
  logic [23:0]        tc_q [1:10];
  logic signed [39:0] prod_p1, prod_t1;
  logic signed [39:0] rnd_p, rnd_t;
  logic signed [26:0] sp_q [2:7];
  logic signed [26:0] st_q [2:7];
  logic signed [42:0] m30_3, m21_3, c01st_q [3:9];
  logic signed [38:0] t1_3;
  logic signed [47:0] a1_4, a3_4;
  logic signed [39:0] t_sum;
  baro_pkg::sat_t     tsat_q [4:11];
  baro_pkg::sat_t     tsat;
  logic signed [54:0] m1_6, m3_6, h_9, u_9;
  logic signed [47:0] a2_7, m3_7;
  logic signed [56:0] p_10, p_rnd;
  baro_pkg::sat_t     psat;

  assign rnd_p = prod_p1 + 40'sd2048;
  assign rnd_t = prod_t1 + 40'sd2048;
  assign t_sum = (40'(c0) <<< 19) + 40'(t1_3) + 40'sd2048;
  assign tsat  = baro_pkg::sat32(43'(signed'(t_sum[39:12])));
  assign p_rnd = p_10 + 57'sd8192;
  assign psat  = baro_pkg::sat32(p_rnd[56:14]);

  always_ff @(posedge clk) begin
    if (en) begin
      pc_q[1] <= sample.pressure_code;
      tc_q[1] <= sample.temperature_code;
      for (int i = 2; i <= 10; i++) begin
        pc_q[i] <= pc_q[i-1];
        tc_q[i] <= tc_q[i-1];
      end
      // scale by reciprocal of the oversampling factor
      prod_p1 <= signed'(sample.pressure_code)
                 * signed'({1'b0, baro_pkg::RECIP[osr_p]});
      prod_t1 <= signed'(sample.temperature_code)
                 * signed'({1'b0, baro_pkg::RECIP[osr_t]});
      sp_q[2] <= rnd_p[38:12];
      st_q[2] <= rnd_t[38:12];
      for (int i = 3; i <= 7; i++) begin
        sp_q[i] <= sp_q[i-1];
        st_q[i] <= st_q[i-1];
      end
      m30_3      <= c30 * sp_q[2];
      m21_3      <= c21 * sp_q[2];
      t1_3       <= c1 * st_q[2];
      c01st_q[3] <= c01 * st_q[2];
      for (int i = 4; i <= 9; i++) c01st_q[i] <= c01st_q[i-1];
      a1_4      <= (48'(c20) <<< 20) + 48'(m30_3);
      a3_4      <= (48'(c11) <<< 20) + 48'(m21_3);
      tsat_q[4] <= tsat;
      for (int i = 5; i <= 11; i++) tsat_q[i] <= tsat_q[i-1];
      a2_7 <= m1_6[47:0] + (48'(c10) <<< 20);
      m3_7 <= m3_6[47:0];
      p_10 <= 57'(h_9) + (57'(c00) <<< 20) + 57'(c01st_q[9]) + 57'(u_9);
      result.pressure_signed    <= signed'(pc_q[10]);
      result.temperature_signed <= signed'(tc_q[10]);
      result.temperature_fixed  <= tsat_q[10].value;
      result.pressure_fixed     <= psat.value;
      result.clipped            <= tsat_q[10].clip || psat.clip;
    end
  end

  assign result.valid = v[11];

  bc_mulq20 u_mul_a1 (.clk(clk), .en(en), .a(a1_4), .s(sp_q[4]), .q(m1_6));
  bc_mulq20 u_mul_a3 (.clk(clk), .en(en), .a(a3_4), .s(sp_q[4]), .q(m3_6));
  bc_mulq20 u_mul_a2 (.clk(clk), .en(en), .a(a2_7), .s(sp_q[7]), .q(h_9));
  bc_mulq20 u_mul_u  (.clk(clk), .en(en), .a(m3_7), .s(st_q[7]), .q(u_9));

  `BC_ASSERT_NOW(a_clip_at_bound, result.valid && result.clipped,
    (result.pressure_fixed == 32'sh7fffffff) || (result.pressure_fixed == 32'sh80000000) ||
    (result.temperature_fixed == 32'sh7fffffff) ||
    (result.temperature_fixed == 32'sh80000000), "clipped set without a bound value")
  `BC_ASSERT_NOW(a_temp_in_range, v[11], !tsat_q[11].clip, "temperature line saturated")
  `BC_ASSERT_NEXT(a_hold_on_stall, !en, v[11] && $stable(result.pressure_fixed),
    "pipeline moved while result stalled")

endmodule

FILE: tb/sv/tb_barometer_compensation.sv
`timescale 1ns / 100ps

module tb_barometer_compensation;

  localparam logic [baro_pkg::CfgIdxW-1:0] CfgSpare = 3'd5;
  localparam logic [baro_pkg::CfgIdxW-1:0] CfgLast  = 3'd7;
  localparam int DrainCycles = 40;

  typedef struct {
    logic signed [23:0] p_raw;
    logic signed [23:0] t_raw;
    logic signed [31:0] t_fix;
    logic signed [31:0] p_fix;
    logic               clip;
  } comp_t;

  localparam longint RecipQ32 [8] = '{8192, 2731, 1170, 546, 16913, 8322, 4128, 2056};

  logic clk;
  logic rst;

  bc_in_if  in_ch ();
  bc_out_if out_ch ();
  bc_cfg_if cfg_ch ();

  barometer_compensation u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  logic [47:0] coef_reg [3];
  logic [2:0]  osr_p_sel;
  logic [2:0]  osr_t_sel;
  comp_t       pending_q [$];
  int          err_cnt;
  bit          src_idle_en;
  bit          snk_stall_en;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint mul_q20(longint a, longint s);
    longint hi;
    longint lo;
    hi = a >>> 20;
    lo = a - (hi <<< 20);
    return hi * s + rnd_shift(lo * s, 20);
  endfunction

  function automatic longint clamp32(longint x, ref logic clip);
    if (x > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic comp_t compensate(logic [23:0] pcode, logic [23:0] tcode);
    logic [143:0] cal;
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint sp, st, t, h, u, p;
    logic clip;
    comp_t r;
    cal = {coef_reg[0], coef_reg[1], coef_reg[2]};
    c0  = longint'(signed'(cal[143:132]));
    c1  = longint'(signed'(cal[131:120]));
    c00 = longint'(signed'(cal[119:100]));
    c10 = longint'(signed'(cal[99:80]));
    c01 = longint'(signed'(cal[79:64]));
    c11 = longint'(signed'(cal[63:48]));
    c20 = longint'(signed'(cal[47:32]));
    c21 = longint'(signed'(cal[31:16]));
    c30 = longint'(signed'(cal[15:0]));
    clip = 1'b0;
    sp = rnd_shift(longint'(signed'(pcode)) * RecipQ32[osr_p_sel], 12);
    st = rnd_shift(longint'(signed'(tcode)) * RecipQ32[osr_t_sel], 12);
    t = clamp32(rnd_shift((c0 <<< 19) + c1 * st, 12), clip);
    h = mul_q20((c20 <<< 20) + c30 * sp, sp);
    h = mul_q20(h + (c10 <<< 20), sp) + (c00 <<< 20);
    u = mul_q20(mul_q20((c11 <<< 20) + c21 * sp, sp), st);
    p = clamp32(rnd_shift(h + c01 * st + u, 14), clip);
    r.p_raw = pcode;
    r.t_raw = tcode;
    r.t_fix = t[31:0];
    r.p_fix = p[31:0];
    r.clip  = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result side: random stalls and field checks
  always @(posedge clk) begin
    comp_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result", out_ch.pressure_fixed, 0);
        end else begin
          e = pending_q.pop_front();
          if (out_ch.pressure_signed !== e.p_raw)
            report_mismatch("pressure_signed", out_ch.pressure_signed, e.p_raw);
          if (out_ch.temperature_signed !== e.t_raw)
            report_mismatch("temperature_signed", out_ch.temperature_signed, e.t_raw);
          if (out_ch.temperature_fixed !== e.t_fix)
            report_mismatch("temperature_fixed", out_ch.temperature_fixed, e.t_fix);
          if (out_ch.pressure_fixed !== e.p_fix)
            report_mismatch("pressure_fixed", out_ch.pressure_fixed, e.p_fix);
          if (out_ch.clipped !== e.clip)
            report_mismatch("clipped", out_ch.clipped, e.clip);
        end
        stall_left = snk_stall_en ? $urandom_range(0, 16) : 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(logic [23:0] pcode, logic [23:0] tcode);
    int gap;
    comp_t e;
    gap = src_idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e = compensate(pcode, tcode);
    in_ch.valid            <= 1'b1;
    in_ch.pressure_code    <= pcode;
    in_ch.temperature_code <= tcode;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(e);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [baro_pkg::CfgIdxW-1:0] idx, logic [47:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      baro_pkg::CFG_COEF0, baro_pkg::CFG_COEF1, baro_pkg::CFG_COEF2:
        coef_reg[idx[1:0]] = val;
      baro_pkg::CFG_OSR_P: osr_p_sel = val[2:0];
      baro_pkg::CFG_OSR_T: osr_t_sel = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                         logic [2:0] op, logic [2:0] ot);
    wait_idle();
    write_reg(baro_pkg::CFG_COEF0, r0);
    write_reg(baro_pkg::CFG_COEF1, r1);
    write_reg(baro_pkg::CFG_COEF2, r2);
    write_reg(baro_pkg::CFG_OSR_P, {45'd0, op});
    write_reg(baro_pkg::CFG_OSR_T, {45'd0, ot});
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 16'hffff)), $urandom()};
  endfunction

  function automatic logic [23:0] rand_code();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 24'hffffff));
      1: return 24'($urandom_range(0, 24'h00ffff));
      2: return 24'hffffff - 24'($urandom_range(0, 24'h00ffff));
      default: return ($urandom_range(0, 1) ? 24'h800000 : 24'h7fffff)
                      ^ 24'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_directed();
    logic [23:0] corner [6] = '{24'h000000, 24'h000001, 24'h7fffff, 24'h800000,
                                24'hffffff, 24'h555555};
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    set_all(48'h7ff800_7ffff8, 48'h000000_000000, 48'h7fff80_007fff, 3'd0, 3'd7);
    foreach (corner[i]) send_pair(corner[i], corner[5 - i]);
    set_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 3'd7, 3'd0);
    foreach (corner[i]) send_pair(corner[i], corner[i]);
    set_all(48'h800800_800008, 48'h000008_000080, 48'h800080_008000, 3'd4, 3'd4);
    foreach (corner[i]) send_pair(corner[i], ~corner[i]);
  endtask

  task automatic test_spare_index();
    set_all(rand48(), rand48(), rand48(), 3'd2, 3'd5);
    write_reg(CfgSpare, {48{1'b1}});
    write_reg(CfgLast, {48{1'b1}});
    repeat (4) send_pair(rand_code(), rand_code());
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_all('0, '0, '0, 3'd0, 3'd0);
      else if (ph == 1) set_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 3'd7, 3'd7);
      else set_all(rand48(), rand48(), rand48(), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
      src_idle_en  = (ph % 3) != 0;
      snk_stall_en = (ph % 4) != 1;
      repeat (200) send_pair(rand_code(), rand_code());
    end
  endtask

  initial begin
    rst = 1'b1;
    err_cnt = 0;
    in_ch.valid = 1'b0;
    in_ch.pressure_code = '0;
    in_ch.temperature_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    coef_reg = '{default: '0};
    osr_p_sel = '0;
    osr_t_sel = '0;
    src_idle_en = 1'b0;
    snk_stall_en = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_spare_index();
    test_random_phases();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
